// File: rtl/brsp_pkg.sv
// Shared types and constants for the block reward penalty core.
package brsp_pkg;

   localparam int AmountWidth = 64;
   localparam int SizeWidth   = 32;
   localparam int ShiftWidth  = 7;
   localparam int ProdWidth   = 128;

   localparam logic [0:0] RegTotalSupply  = 1'd0;
   localparam logic [0:0] RegEmissionShift = 1'd1;

   localparam logic [7:0] FeePenaltyVersion = 8'd2;

   // classified item handed from the front end to the back end
   typedef struct packed {
      logic                   error;
      logic                   base_pen;
      logic                   fee_pen;
      logic [SizeWidth-1:0]   median;
      logic [63:0]            factor;
      logic [AmountWidth-1:0] base;
      logic [AmountWidth-1:0] fee;
   } job_type;

endpackage

// File: rtl/brsp_front.sv
// Front end: checks bounds, computes base reward and penalty factor.
module brsp_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [brsp_pkg::AmountWidth-1:0] total_supply,
   input  logic [brsp_pkg::ShiftWidth-1:0]  emission_shift,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [7:0]                      version,
   input  logic [brsp_pkg::SizeWidth-1:0]  median_bytes,
   input  logic [brsp_pkg::SizeWidth-1:0]  size_bytes,
   input  logic [brsp_pkg::AmountWidth-1:0] generated_coins,
   input  logic [brsp_pkg::AmountWidth-1:0] fee_amount,
   output logic                            out_valid,
   input  logic                            out_ready,
   output brsp_pkg::job_type               out_job
);
   logic              valid_ff, valid_in;
   brsp_pkg::job_type job_ff, job_in;
   logic [32:0] twice_med;
   logic [63:0] remain;
   logic        over;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_job = job_ff;

   always_comb begin
      twice_med = {median_bytes, 1'b0};
      remain = total_supply - generated_coins;
      over = size_bytes > median_bytes;
      job_in.error = (generated_coins > total_supply) || ({1'b0, size_bytes} > twice_med);
      job_in.median = median_bytes;
      job_in.factor = {32'd0, size_bytes} * ({31'd0, twice_med} - {32'd0, size_bytes});
      job_in.base = emission_shift[6] ? '0 : (remain >> emission_shift[5:0]);
      job_in.fee = fee_amount;
      job_in.base_pen = over && (job_in.base != '0);
      job_in.fee_pen = over && (version >= brsp_pkg::FeePenaltyVersion) && (fee_amount != '0);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (in_ready && in_valid) job_ff <= job_in;
   end
endmodule

// File: rtl/brsp_queue.sv
// Short FIFO between front and back ends.
module brsp_queue #(
   parameter int Depth = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  brsp_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output brsp_pkg::job_type out_job
);
   localparam int Aw = $clog2(Depth);
   brsp_pkg::job_type mem_ff [Depth];
   logic [Aw-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [Aw:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = cnt_ff != Depth[Aw:0];
   assign out_valid = cnt_ff != '0;
   assign out_job = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_in = push ? ((wr_ff == Aw'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in = pop ? ((rd_ff == Aw'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + {{Aw{1'b0}}, push} - {{Aw{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_job;
   end
endmodule

// File: rtl/brsp_back.sv
// Back end: pipelined 128-bit product, two radix-2 divisions, result output.
module brsp_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  brsp_pkg::job_type                in_job,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [brsp_pkg::AmountWidth-1:0] reward_amount,
   output logic [brsp_pkg::AmountWidth-1:0] emission_delta,
   output logic                             error
);
   // stage 0..3: partial products (32x32), stage 4..259: bit-serial restoring division pipelines, stage 260: output
   localparam int Pw = brsp_pkg::ProdWidth;
   localparam int Ns = 4 + 2 * Pw + 1;

   typedef struct packed {
      logic        valid;
      logic        error;
      logic        base_pen;
      logic        fee_pen;
      logic [31:0] median;
      logic [63:0] base;
      logic [63:0] fee;
      logic [63:0] factor;
      logic [Pw-1:0] bn;
      logic [Pw-1:0] fn;
      logic [32:0] br;
      logic [32:0] fr;
   } stg_type;

   stg_type st_ff [Ns];
   stg_type st_in [Ns];
   logic adv;

   assign adv = !st_ff[Ns-1].valid || out_ready;
   assign in_ready = adv;

   function automatic logic [Pw-1:0] part_mul(input logic [63:0] a, input logic [63:0] b,
                                              input int k);
      logic [31:0] x, y;
      logic [63:0] p;
      x = (k[0]) ? a[63:32] : a[31:0];
      y = (k[1]) ? b[63:32] : b[31:0];
      p = x * y;
      return {64'd0, p} << (32 * (k[0] + k[1]));
   endfunction

   function automatic void div_step(input logic [Pw-1:0] n_i, input logic [32:0] r_i,
                                    input logic [31:0] d, output logic [Pw-1:0] n_o,
                                    output logic [32:0] r_o);
      logic [33:0] t;
      t = {r_i, n_i[Pw-1]};
      if (t >= {2'b0, d}) begin
         r_o = 33'(t - {2'b0, d});
         n_o = {n_i[Pw-2:0], 1'b1};
      end else begin
         r_o = t[32:0];
         n_o = {n_i[Pw-2:0], 1'b0};
      end
   endfunction

   always_comb begin
      stg_type s;
      s = '0;
      s.valid = in_valid;
      s.error = in_job.error;
      s.base_pen = in_job.base_pen;
      s.fee_pen = in_job.fee_pen;
      s.median = in_job.median;
      s.base = in_job.base;
      s.fee = in_job.fee;
      s.factor = in_job.factor;
      s.bn = part_mul(in_job.base, in_job.factor, 0);
      s.fn = part_mul(in_job.fee, in_job.factor, 0);
      st_in[0] = s;
      for (int i = 1; i < Ns; i++) begin
         s = st_ff[i-1];
         if (i < 4) begin
            s.bn = s.bn + part_mul(s.base, s.factor, i);
            s.fn = s.fn + part_mul(s.fee, s.factor, i);
         end else if (i < 4 + 2 * Pw) begin
            if (i == 4 || i == 4 + Pw) begin
               s.br = '0;
               s.fr = '0;
            end
            div_step(s.bn, s.br, s.median, s.bn, s.br);
            div_step(s.fn, s.fr, s.median, s.fn, s.fr);
         end
         st_in[i] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Ns; i++) st_ff[i].valid <= 1'b0;
      end else if (adv) begin
         for (int i = 0; i < Ns; i++) st_ff[i] <= st_in[i];
      end
   end

   logic [63:0] pbase, pfee;
   assign pbase = st_ff[Ns-1].base_pen ? st_ff[Ns-1].bn[63:0] : st_ff[Ns-1].base;
   assign pfee = st_ff[Ns-1].fee_pen ? st_ff[Ns-1].fn[63:0] : st_ff[Ns-1].fee;
   assign out_valid = st_ff[Ns-1].valid;
   assign error = st_ff[Ns-1].error;
   assign reward_amount = error ? '0 : pbase + pfee;
   assign emission_delta = error ? '0 : pbase - (st_ff[Ns-1].fee - pfee);
endmodule

// File: rtl/block_reward_with_size_penalty_core.sv
// Top level of the block reward with size penalty core.
// One transaction per cycle sustained while rsp_tready stays high; a result
// passes through the front stage, FIFO, four partial-product stages, two
// successive 128-step bit-serial divisions by the median (256 stages) and the
// output stage. Throughput is set by the fully pipelined divider; a held
// result stalls the whole back pipeline, and the FIFO decouples front and
// back stalls.
module block_reward_with_size_penalty_core #(
   parameter int QueueDepth = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // version[7:0], median_bytes[39:8], size_bytes[71:40], generated_coins[135:72],
   // fee_amount[199:136]
   input  logic [199:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // reward_amount[63:0], emission_delta[127:64]
   output logic [127:0] rsp_tdata,
   // error[0]
   output logic         rsp_tuser
);
   logic [63:0] total_supply_ff;
   logic [6:0]  emission_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_supply_ff <= '1;
         emission_shift_ff <= 7'd18;
      end else if (csr_we) begin
         case (csr_index)
            brsp_pkg::RegTotalSupply: total_supply_ff <= csr_wdata;
            brsp_pkg::RegEmissionShift: emission_shift_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   logic f_valid, f_ready, q_valid, q_ready;
   brsp_pkg::job_type f_job, q_job;
   logic [63:0] reward, delta;
   logic err;

   brsp_front u_front (
      .clock, .reset,
      .total_supply(total_supply_ff), .emission_shift(emission_shift_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .version(req_tdata[7:0]), .median_bytes(req_tdata[39:8]),
      .size_bytes(req_tdata[71:40]), .generated_coins(req_tdata[135:72]),
      .fee_amount(req_tdata[199:136]),
      .out_valid(f_valid), .out_ready(f_ready), .out_job(f_job)
   );

   brsp_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
   );

   brsp_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .reward_amount(reward), .emission_delta(delta), .error(err)
   );

   assign rsp_tdata = {delta, reward};
   assign rsp_tuser = err;
endmodule
